// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands included by sha256_stream_hasher_top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 64;
   localparam int unsigned ROUNDS  = 64;

   localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;

   typedef logic [WORD_W-1:0] word_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_DIGEST
   } state_type;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// File: rtl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a word stream, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries message words, big-endian, with a byte count and a last
//   flag. Non-final words count as four bytes. rsp_* returns the eight
//   digest words, index 0 first, after the final word of each message.
// Timing:
//   Words are taken while the sequencer is idle. The word that completes a
//   16-word block starts the compression on the single round unit: the
//   rounds, then the feed-forward, during which req_ready is low. After the
//   final word the padding and length words are pushed one per cycle, with
//   a compression whenever a block fills, one or two in all; then the
//   digest is shown one word per cycle while rsp_ready is high.
// Reset:
//   Synchronous reset loads the initial hash values and clears the bit
//   count and sequencer. A stalled receiver simply holds the digest word;
//   no new request is taken until all eight words are delivered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha_pkg::state_type state_ff, state_in;

   sha_pkg::word_type hash_ff [8];
   sha_pkg::word_type work_ff [8];
   sha_pkg::word_type win_ff  [16];

   logic [sha_pkg::COUNT_W-1:0] bits_ff;
   logic [3:0] pos_ff;
   logic [5:0] round_ff;
   logic [2:0] idx_ff;
   logic       pad_ff;
   logic       pend80_ff;
   logic       hi_sent_ff;
   logic       len_done_ff;

   logic              req_fire, rsp_fire;
   logic              push_en;
   sha_pkg::word_type push_data;
   logic              push_80, push_hi, push_lo;
   logic              block_full;
   logic [2:0]        nb_eff;
   sha_pkg::word_type byte_mask, pad_mark;
   sha_pkg::word_type sched_new;
   sha_pkg::word_type t1, t2, ch, maj;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Byte count of a final word, above four taken as four
   assign nb_eff    = (req_valid_bytes >= 3'd4) ? 3'd4 : req_valid_bytes;
   assign byte_mask = ~(32'hFFFF_FFFF >> {nb_eff[1:0], 3'b000});
   assign pad_mark  = sha_pkg::PAD_WORD >> {nb_eff[1:0], 3'b000};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (block_full) state_in = sha_pkg::ST_ROUND;
               else if (req_last) state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_PAD: begin
            if (block_full) state_in = sha_pkg::ST_ROUND;
         end
         sha_pkg::ST_ROUND: begin
            if (round_ff == 6'(sha_pkg::ROUNDS - 1)) state_in = sha_pkg::ST_FOLD;
         end
         sha_pkg::ST_FOLD: begin
            priority if (len_done_ff) state_in = sha_pkg::ST_DIGEST;
            else if (pad_ff)         state_in = sha_pkg::ST_PAD;
            else                     state_in = sha_pkg::ST_IDLE;
         end
         sha_pkg::ST_DIGEST: begin
            if (rsp_fire && idx_ff == 3'd7) state_in = sha_pkg::ST_IDLE;
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   // Handshakes and the word pushed into the schedule window
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      push_en   = 1'b0;
      push_data = '0;
      push_80   = 1'b0;
      push_hi   = 1'b0;
      push_lo   = 1'b0;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            push_en   = req_valid;
            if (!req_last || nb_eff == 3'd4) push_data = req_message_word;
            else push_data = (req_message_word & byte_mask) | pad_mark;
         end
         sha_pkg::ST_PAD: begin
            push_en = 1'b1;
            priority if (pend80_ff) begin
               push_80   = 1'b1;
               push_data = sha_pkg::PAD_WORD;
            end else if (pos_ff == 4'd14) begin
               push_hi   = 1'b1;
               push_data = bits_ff[63:32];
            end else if (pos_ff == 4'd15 && hi_sent_ff) begin
               push_lo   = 1'b1;
               push_data = bits_ff[31:0];
            end else begin
               push_data = '0;
            end
         end
         sha_pkg::ST_DIGEST: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign block_full = push_en && (pos_ff == 4'd15);

   // Round unit: schedule extension and one compression round
   assign sched_new = sha_pkg::small_sigma1(win_ff[14]) + win_ff[9]
                    + sha_pkg::small_sigma0(win_ff[1]) + win_ff[0];
   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + sha_pkg::big_sigma1(work_ff[4]) + ch
              + sha_pkg::ROUND_K[round_ff] + win_ff[0];
   assign t2  = sha_pkg::big_sigma0(work_ff[0]) + maj;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha_pkg::ST_IDLE;
         bits_ff     <= '0;
         pos_ff      <= '0;
         round_ff    <= '0;
         idx_ff      <= '0;
         pad_ff      <= 1'b0;
         pend80_ff   <= 1'b0;
         hi_sent_ff  <= 1'b0;
         len_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (push_en) pos_ff <= pos_ff + 4'd1;
         if (state_ff == sha_pkg::ST_ROUND) round_ff <= round_ff + 6'd1;
         if (req_fire) begin
            bits_ff <= bits_ff + (req_last ? 64'({nb_eff, 3'b000}) : 64'd32);
            if (req_last) begin
               pad_ff    <= 1'b1;
               pend80_ff <= (nb_eff == 3'd4);
            end
         end
         if (push_80) pend80_ff   <= 1'b0;
         if (push_hi) hi_sent_ff  <= 1'b1;
         if (push_lo) len_done_ff <= 1'b1;
         if (state_ff == sha_pkg::ST_FOLD && len_done_ff) begin
            pad_ff      <= 1'b0;
            hi_sent_ff  <= 1'b0;
            len_done_ff <= 1'b0;
         end
         if (rsp_fire) begin
            idx_ff <= idx_ff + 3'd1;
            if (idx_ff == 3'd7) bits_ff <= '0;
         end
      end
   end

   // Hash state: feed-forward after a block, shifted out as the digest and refilled with the initial values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha_pkg::INIT_HASH[i];
      end else if (state_ff == sha_pkg::ST_FOLD) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + work_ff[i];
      end else if (rsp_fire) begin
         for (int i = 0; i < 7; i++) hash_ff[i] <= hash_ff[i+1];
         hash_ff[7] <= sha_pkg::INIT_HASH[idx_ff];
      end
   end

   // Working variables
   always_ff @(posedge clock) begin
      if (block_full) begin
         for (int i = 0; i < 8; i++) work_ff[i] <= hash_ff[i];
      end else if (state_ff == sha_pkg::ST_ROUND) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
   end

   // Rolling schedule window, oldest word at index 0
   always_ff @(posedge clock) begin
      if (push_en || state_ff == sha_pkg::ST_ROUND) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= (state_ff == sha_pkg::ST_ROUND) ? sched_new : push_data;
      end
   end

   assign rsp_digest_word = hash_ff[0];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   // Checks
   `ASSERT_ALWAYS(a_one_side, !(req_ready && rsp_valid), "request and response sides both open")
   `ASSERT_CLK(a_round_end, (state_ff == sha_pkg::ST_ROUND && round_ff == 6'd63) |=> (state_ff == sha_pkg::ST_FOLD), "last round not followed by feed-forward")
   `ASSERT_CLK(a_digest_aligned, (state_ff == sha_pkg::ST_DIGEST) |-> (pos_ff == 4'd0 && idx_ff == rsp_word_index), "digest shown with partial block pending")
   `ASSERT_CLK(a_digest_done, (rsp_fire && rsp_last_word) |=> (state_ff == sha_pkg::ST_IDLE && bits_ff == 64'd0 && hash_ff[0] == sha_pkg::INIT_HASH[0]), "state not restored after digest")

endmodule

// File: tb/sv/sha256_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the SHA-256 stream hasher, computes the digest of
// every message it sees go in, and compares the eight digest words that come
// out against it, in order.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      sha_pkg::word_type digest;
      logic [2:0]        index;
      logic              last;
   } digest_rec_type;

   // Shadow copy of the hasher state
   sha_pkg::word_type hash_q [8];
   sha_pkg::word_type sched_q [16];
   logic [63:0]       bit_total;
   logic [3:0]        fill_pos;

   digest_rec_type expected_digests [$];
   digest_rec_type exp_rec;
   int             mismatches;

   function automatic sha_pkg::word_type rotr(input sha_pkg::word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // 64 rounds over the rolling schedule, then feed-forward
   function automatic void compress_block();
      sha_pkg::word_type v [8];
      sha_pkg::word_type w, w2, w15, sum0, sum1, ch, maj, t1, t2;
      v = hash_q;
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            w = sched_q[t];
         end else begin
            w2  = sched_q[(t - 2) & 15];
            w15 = sched_q[(t - 15) & 15];
            w = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + sched_q[(t - 7) & 15]
                + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + sched_q[t & 15];
            sched_q[t & 15] = w;
         end
         sum1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
         ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1   = v[7] + sum1 + ch + sha_pkg::ROUND_K[t] + w;
         sum0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
         maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t2   = sum0 + maj;
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         hash_q[i] = hash_q[i] + v[i];
   endfunction

   // Append one word to the current block; a full block is compressed
   function automatic void append_word(input sha_pkg::word_type w);
      sched_q[fill_pos] = w;
      fill_pos = fill_pos + 4'd1;
      if (fill_pos == 4'd0)
         compress_block();
   endfunction

   function automatic void clear_message();
      hash_q    = sha_pkg::INIT_HASH;
      bit_total = '0;
      fill_pos  = '0;
   endfunction

   // Absorb one request; the last word of a message yields the digest
   function automatic void hash_request(input sha_pkg::word_type word,
                                        input logic [2:0] nbytes,
                                        input logic is_last);
      logic [2:0]        used;
      sha_pkg::word_type keep;
      digest_rec_type    rec;
      if (!is_last) begin
         bit_total = bit_total + 64'd32;
         append_word(word);
         return;
      end
      used = (nbytes > 3'd4) ? 3'd4 : nbytes;
      bit_total = bit_total + 64'(used) * 64'd8;
      if (used == 3'd4) begin
         append_word(word);
         append_word(sha_pkg::PAD_WORD);
      end else begin
         keep = (used == 3'd0) ? '0 : ('1 << (32 - 8 * used));
         append_word((word & keep) | (sha_pkg::PAD_WORD >> (8 * used)));
      end
      while (fill_pos != 4'd14)
         append_word('0);
      append_word(bit_total[63:32]);
      append_word(bit_total[31:0]);
      for (int i = 0; i < 8; i++) begin
         rec.digest = hash_q[i];
         rec.index  = 3'(i);
         rec.last   = (i == 7);
         expected_digests.push_back(rec);
      end
      clear_message();
   endfunction

   // Predict on accepted requests, compare accepted digest words
   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         expected_digests.delete();
         mismatches = 0;
      end else begin
         if (req_valid && req_ready)
            hash_request(req_message_word, req_valid_bytes, req_last);
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               $display("%0t: unexpected digest word %h index %0d last %b",
                        $time, rsp_digest_word, rsp_word_index, rsp_last_word);
               mismatches++;
            end else begin
               exp_rec = expected_digests.pop_front();
               if (rsp_digest_word !== exp_rec.digest) begin
                  $display("%0t: digest_word mismatch: expected %h, actual %h",
                           $time, exp_rec.digest, rsp_digest_word);
                  mismatches++;
               end
               if (rsp_word_index !== exp_rec.index) begin
                  $display("%0t: word_index mismatch: expected %0d, actual %0d",
                           $time, exp_rec.index, rsp_word_index);
                  mismatches++;
               end
               if (rsp_last_word !== exp_rec.last) begin
                  $display("%0t: last_word mismatch: expected %b, actual %b",
                           $time, exp_rec.last, rsp_last_word);
                  mismatches++;
               end
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_digests.size();
   end

endmodule

// File: tb/sv/sha256_stream_hasher_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top_test
// Drives messages into the SHA-256 stream hasher: short directed messages
// covering byte counts and the two-block padding boundary, then random
// messages of random length, with random stalls on both channels and one
// long response stall. The digest checker does all comparisons.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top_test;

   localparam int TOTAL_REQUESTS = 150;
   localparam int LONG_STALL     = 600;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_message_word;
   logic [2:0]  req_valid_bytes;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   int   error_count;
   int   pending_count;
   int   requests_sent;
   int   gap_odds;
   int   idle_cycles;
   logic random_phase;
   logic quiet_phase;
   logic long_stall_done;

   sha256_stream_hasher_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_word (req_message_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_word_index   (rsp_word_index),
      .rsp_last_word    (rsp_last_word)
   );

   sha256_digest_checker digest_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_word (req_message_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_word_index   (rsp_word_index),
      .rsp_last_word    (rsp_last_word),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Offer one request at a falling edge and hold it until it is taken
   task automatic offer_request(input logic [31:0] word, input logic [2:0] nbytes,
                                input logic is_last);
      if (!quiet_phase && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_message_word <= word;
      req_valid_bytes  <= nbytes;
      req_last         <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   // Random body words, then a final word with the given byte count
   task automatic send_message(input int body_words, input logic [2:0] final_bytes);
      for (int i = 0; i < body_words; i++)
         offer_request($urandom, 3'($urandom_range(0, 7)), 1'b0);
      offer_request($urandom, final_bytes, 1'b1);
   endtask

   // Request side
   initial begin
      int body_words;
      logic [2:0] final_bytes;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_message_word = '0;
      req_valid_bytes  = '0;
      req_last         = 1'b0;
      random_phase     = 1'b0;
      quiet_phase      = 1'b0;
      requests_sent    = 0;
      gap_odds         = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty message, each byte count, counts above four,
      // ignored byte count on a body word, 56-byte message needing two blocks
      offer_request(32'hffff_ffff, 3'd0, 1'b1);
      offer_request(32'h6162_6300, 3'd3, 1'b1);
      offer_request(32'hffff_ffff, 3'd1, 1'b1);
      offer_request(32'hffff_ffff, 3'd2, 1'b1);
      offer_request(32'h0000_0000, 3'd4, 1'b1);
      offer_request(32'hffff_ffff, 3'd7, 1'b1);
      offer_request(32'h0000_0000, 3'd0, 1'b0);
      offer_request(32'hffff_ffff, 3'd5, 1'b1);
      offer_request(32'hffff_ffff, 3'd6, 1'b1);
      send_message(13, 3'd4);

      // Random messages; lengths favor the one- and two-block boundaries
      random_phase <= 1'b1;
      while (requests_sent < TOTAL_REQUESTS) begin
         if (requests_sent > TOTAL_REQUESTS - 30)
            quiet_phase = 1'b1;
         gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
         case ($urandom_range(0, 3))
            0: body_words = $urandom_range(0, 3);
            1: body_words = $urandom_range(12, 16);
            2: body_words = $urandom_range(4, 31);
            default: body_words = $urandom_range(27, 33);
         endcase
         final_bytes = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
         send_message(body_words, final_bytes);
      end
      req_valid <= 1'b0;

      // Drain
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("sha256_stream_hasher_top_test OK");
      else
         $display("sha256_stream_hasher_top_test NOT OK");
      $finish;
   end

   // Response side: short random stalls, one long stall to back up the input
   initial begin
      rsp_ready       = 1'b0;
      long_stall_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (random_phase && !long_stall_done) begin
            long_stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL) @(negedge clock);
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("sha256_stream_hasher_top_test NOT OK");
            $finish;
         end
      end
   end

endmodule
